// ----- rtl/nbi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Newton backward interpolator package
// Shared types, operation and status codes, and the arithmetic limit.
// ----------------------------------------------------------------------------
package nbi_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FEW       = 2'd1,
    ST_ZERO_STEP = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY,
    S_DIFF,
    S_DIVU_GO,
    S_DIVU_W,
    S_MULT_GO,
    S_MULT_W,
    S_MULC_GO,
    S_MULC_W,
    S_DIVC_GO,
    S_DIVC_W,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] value;
  } unit_res_t;

  localparam logic [63:0] LIMIT = 64'h2000_0000_0000_0000;

endpackage : nbi_pkg
`default_nettype wire

// ----- rtl/newton_backward_interpolator_unit.sv -----
// Clear and load are done on acceptance. Evaluate runs the difference table
// through the serial multiplier and divider; with fewer than two points or a
// zero step it answers at once. One item is in work at a time. Reset is
// synchronous and active low; it empties the store and clears the abscissas.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Newton backward interpolator
// Stores equally spaced samples and evaluates the backward-difference
// interpolation polynomial at a query point under a small sequencer.
// ----------------------------------------------------------------------------
module newton_backward_interpolator_unit #(
  parameter int MAX_POINTS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [95:0] in_tdata,   // abscissa, ordinate, query_point
  input  wire logic [1:0]  in_tuser,   // operation
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // interpolated_value
  output      logic [1:0]  out_tuser   // status
);
  import nbi_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int DW = 32 + MAX_POINTS;

  state_t state_r, state_nxt;

  logic signed [31:0] ord_r [MAX_POINTS];
  logic signed [DW-1:0] work_r [MAX_POINTS];
  logic signed [DW-1:0] dif_r [MAX_POINTS];
  logic [31:0] first_r, second_r, last_r, query_r;
  logic [CW-1:0] count_r, idx_r;
  logic [63:0] u_r, coef_r, sum_r;
  logic        sat_r;
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [1:0]  out_status_r;

  logic        accept;
  op_t         op;
  logic [32:0] step;
  logic [32:0] qdiff;
  logic [IW-1:0] last_idx;
  logic [63:0] sum_add;
  logic [63:0] sum_clamped;
  logic        sum_sat;

  logic        mul_start, div_start;
  logic [63:0] mul_b, div_a, div_b;
  unit_res_t   mul_res, div_res;

  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign step      = {second_r[31], second_r} - {first_r[31], first_r};
  assign qdiff     = {query_r[31], query_r} - {last_r[31], last_r};
  assign last_idx  = IW'(count_r - CW'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  nbi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .op_a(coef_r), .op_b(mul_b), .res(mul_res)
  );

  nbi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_a), .divisor(div_b), .res(div_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && op == OP_EVAL && count_r >= CW'(2) && step != 33'd0) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY:    state_nxt = S_DIFF;
      S_DIFF: begin
        if (idx_r == count_r) begin
          state_nxt = S_DIVU_GO;
        end
      end
      S_DIVU_GO: state_nxt = S_DIVU_W;
      S_DIVU_W: begin
        if (div_res.done) begin
          state_nxt = S_MULT_GO;
        end
      end
      S_MULT_GO: state_nxt = S_MULT_W;
      S_MULT_W: begin
        if (mul_res.done) begin
          state_nxt = (idx_r + CW'(1) == count_r) ? S_FIN : S_MULC_GO;
        end
      end
      S_MULC_GO: state_nxt = S_MULC_W;
      S_MULC_W: begin
        if (mul_res.done) begin
          state_nxt = S_DIVC_GO;
        end
      end
      S_DIVC_GO: state_nxt = S_DIVC_W;
      S_DIVC_W: begin
        if (div_res.done) begin
          state_nxt = S_MULT_GO;
        end
      end
      S_FIN:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start = (state_r == S_MULT_GO) || (state_r == S_MULC_GO);
    div_start = (state_r == S_DIVU_GO) || (state_r == S_DIVC_GO);
    if (state_r == S_MULT_GO) begin
      mul_b = 64'(dif_r[idx_r[IW-1:0]]);
    end else begin
      mul_b = u_r + (64'(idx_r - CW'(1)) << FRAC_BITS);
    end
    if (state_r == S_DIVU_GO) begin
      div_a = 64'(signed'(qdiff)) << FRAC_BITS;
      div_b = 64'(signed'(step));
    end else begin
      div_a = coef_r;
      div_b = 64'(idx_r);
    end
    sum_add = sum_r + mul_res.value;
    sum_sat = 1'b0;
    sum_clamped = sum_add;
    if (!sum_add[63] && sum_add > LIMIT) begin
      sum_clamped = LIMIT;
      sum_sat     = 1'b1;
    end else if (sum_add[63] && (64'd0 - sum_add) > LIMIT) begin
      sum_clamped = 64'd0 - LIMIT;
      sum_sat     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && count_r < CW'(MAX_POINTS)) begin
      ord_r[count_r[IW-1:0]] <= in_tdata[63:32];
    end
    if (accept) begin
      query_r <= in_tdata[95:64];
    end
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (state_r == S_COPY) begin
        work_r[j] <= DW'(ord_r[j]);
      end else if (state_r == S_DIFF && idx_r != count_r && CW'(j) >= idx_r && j > 0) begin
        work_r[j] <= work_r[j] - work_r[j-1];
      end
    end
    if (state_r == S_DIFF) begin
      dif_r[IW'(idx_r - CW'(1))] <= work_r[last_idx];
    end
    if (state_r == S_DIVU_W && div_res.done) begin
      u_r    <= div_res.value;
      coef_r <= div_res.value;
      sum_r  <= 64'(dif_r[0]);
    end
    if (state_r == S_MULT_W && mul_res.done) begin
      sum_r <= sum_clamped;
    end
    if (state_r == S_MULC_W && mul_res.done) begin
      coef_r <= mul_res.value;
    end
    if (state_r == S_DIVC_W && div_res.done) begin
      coef_r <= div_res.value;
    end
    if (state_r == S_IDLE && accept && op == OP_EVAL) begin
      out_value_r  <= '0;
      out_status_r <= (count_r < CW'(2)) ? ST_FEW : ST_ZERO_STEP;
    end
    if (state_r == S_FIN) begin
      if (!sum_r[63] && sum_r > 64'h0000_0000_7FFF_FFFF) begin
        out_value_r  <= 32'h7FFF_FFFF;
        out_status_r <= ST_SAT;
      end else if (sum_r[63] && sum_r < 64'hFFFF_FFFF_8000_0000) begin
        out_value_r  <= 32'h8000_0000;
        out_status_r <= ST_SAT;
      end else begin
        out_value_r  <= sum_r[31:0];
        out_status_r <= sat_r ? ST_SAT : ST_OK;
      end
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      last_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && accept) begin
        unique case (op)
          OP_CLEAR: count_r <= '0;
          OP_LOAD: begin
            if (count_r < CW'(MAX_POINTS)) begin
              if (count_r == CW'(0)) begin
                first_r <= in_tdata[31:0];
              end
              if (count_r == CW'(1)) begin
                second_r <= in_tdata[31:0];
              end
              last_r  <= in_tdata[31:0];
              count_r <= count_r + CW'(1);
            end
          end
          OP_EVAL: begin
            sat_r <= 1'b0;
            if (count_r < CW'(2) || step == 33'd0) begin
              out_valid_r <= 1'b1;
            end
          end
          OP_NONE: ;
          default: ;
        endcase
      end
      if (state_r == S_COPY) begin
        idx_r <= CW'(1);
      end
      if (state_r == S_DIFF && idx_r != count_r) begin
        idx_r <= idx_r + CW'(1);
      end
      if (state_r == S_DIVU_W && div_res.done) begin
        idx_r <= CW'(1);
      end
      if (state_r == S_MULT_W && mul_res.done) begin
        sat_r <= sat_r | mul_res.sat | sum_sat;
        idx_r <= idx_r + CW'(1);
      end
      if (state_r == S_MULC_W && mul_res.done) begin
        sat_r <= sat_r | mul_res.sat;
      end
      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
      end
    end
  end

endmodule : newton_backward_interpolator_unit
`default_nettype wire

// ----- rtl/nbi_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial fixed-point multiplier
// Shift-and-add signed product, scaled down by the fraction
// bits with the magnitude truncated and clamped to the internal limit.
// ----------------------------------------------------------------------------
module nbi_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       op_a,
  input  wire logic [63:0]       op_b,
  output nbi_pkg::unit_res_t     res
);
  import nbi_pkg::*;

  logic [127:0] prod_r, prod_nxt;
  logic [63:0]  mag_a_r, mag_a_nxt;
  logic         neg_r, neg_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [64:0]  acc;
  logic [63:0]  mag_b;
  logic [63:0]  rlo;
  logic         sat;
  logic [63:0]  r;

  always_comb begin
    mag_b     = op_b[63] ? (64'd0 - op_b) : op_b;
    acc       = {1'b0, prod_r[127:64]} + (prod_r[0] ? {1'b0, mag_a_r} : 65'd0);
    prod_nxt  = prod_r;
    mag_a_nxt = mag_a_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      mag_a_nxt = op_a[63] ? (64'd0 - op_a) : op_a;
      neg_nxt   = op_a[63] ^ op_b[63];
      prod_nxt  = {64'd0, mag_b};
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {acc, prod_r[63:1]};
      cnt_nxt  = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mag_a_r <= mag_a_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    rlo = prod_r[63 + FRAC_BITS:FRAC_BITS];
    sat = (|prod_r[127:64 + FRAC_BITS]) || (rlo > LIMIT);
    r   = sat ? LIMIT : rlo;
    res.done  = done_r;
    res.sat   = sat;
    res.value = neg_r ? (64'd0 - r) : r;
  end

endmodule : nbi_mul
`default_nettype wire

// ----- rtl/nbi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of magnitudes; the quotient is truncated towards zero.
// ----------------------------------------------------------------------------
module nbi_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       dividend,
  input  wire logic [63:0]       divisor,
  output nbi_pkg::unit_res_t     res
);
  import nbi_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dv_r, dv_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] sh;
  logic [65:0] diff;

  always_comb begin
    sh       = {rem_r, quo_r[63]};
    diff     = {1'b0, sh} - {2'b00, dv_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dv_nxt   = dv_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend[63] ? (64'd0 - dividend) : dividend;
      dv_nxt   = divisor[63] ? (64'd0 - divisor) : divisor;
      neg_nxt  = dividend[63] ^ divisor[63];
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[65]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    res.done  = done_r;
    res.sat   = 1'b0;
    res.value = neg_r ? (64'd0 - quo_r) : quo_r;
  end

endmodule : nbi_div
`default_nettype wire
